// ===== design/lfs_pkg.sv =====
// Shared types, constants and weight table for the line follow steering block.
package lfs_pkg;

  localparam int SensorCount = 8;
  localparam int DigitBits = 2;
  localparam int DigitCount = SensorCount / DigitBits;
  localparam int QuotBits = 4;

  localparam logic [1:0] CfgCornerSteer = 2'd0;
  localparam logic [1:0] CfgSteerGain = 2'd1;
  localparam logic [1:0] CfgCruiseDrive = 2'd2;

  localparam logic [1:0] ModeLost = 2'd0;
  localparam logic [1:0] ModeTrack = 2'd1;
  localparam logic [1:0] ModeTurn = 2'd2;

  localparam logic signed [7:0] LostPosition = 8'sd127;
  localparam logic [2:0] TurnMinHits = 3'd3;
  localparam logic [2:0] TurnMaxOther = 3'd2;

  localparam logic [9:0] CornerSteerReset = 10'd0;
  localparam logic [11:0] SteerGainReset = 12'd256;
  localparam logic [14:0] CruiseDriveReset = 15'd0;

  typedef logic signed [5:0] weight_t;

  typedef struct packed {
    logic [2:0] left_hits;
    logic [2:0] right_hits;
    weight_t    weight_sum;
  } scan_t;

  typedef struct packed {
    logic [QuotBits-1:0] quot;
    logic [14:0]         prod;
  } quot_t;

  typedef struct packed {
    logic signed [7:0]  position;
    logic signed [19:0] steer;
    logic [1:0]         track_mode;
    logic               turn_side;
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
  } result_t;

  function automatic weight_t sensor_weight(input logic [2:0] idx);
    weight_t w;
    unique case (idx)
      3'd0: w = -6'sd8;
      3'd1: w = -6'sd6;
      3'd2: w = -6'sd4;
      3'd3: w = -6'sd1;
      3'd4: w = 6'sd1;
      3'd5: w = 6'sd4;
      3'd6: w = 6'sd6;
      3'd7: w = 6'sd8;
      default: w = 6'sd0;
    endcase
    return w;
  endfunction

endpackage

// ===== design/lfs_scan.sv =====
// Digit-serial scan: hit counts per half and weighted sum, two sensors per shift cycle.
module lfs_scan (
  input  logic          clk,
  input  logic          load,
  input  logic          shift,
  input  logic [7:0]    sensor_bits,
  output lfs_pkg::scan_t scan
);

  logic [7:0]      bits_r, bits_nxt;
  logic [1:0]      digit_r, digit_nxt;
  lfs_pkg::scan_t  acc_r, acc_nxt;
  logic [2:0]      new_hits;
  lfs_pkg::weight_t new_sum;
  lfs_pkg::weight_t w0, w1;

  always_comb begin
    bits_nxt  = bits_r;
    digit_nxt = digit_r;
    acc_nxt   = acc_r;
    w0 = bits_r[0] ? 6'sd0 : lfs_pkg::sensor_weight({digit_r, 1'b0});
    w1 = bits_r[1] ? 6'sd0 : lfs_pkg::sensor_weight({digit_r, 1'b1});
    new_sum  = w0 + w1;
    new_hits = {2'b00, ~bits_r[0]} + {2'b00, ~bits_r[1]};
    if (load) begin
      bits_nxt  = sensor_bits;
      digit_nxt = 2'd0;
      acc_nxt   = '0;
    end else if (shift) begin
      bits_nxt  = {2'b00, bits_r[7:2]};
      digit_nxt = digit_r + 2'd1;
      if (!digit_r[1]) begin
        acc_nxt.left_hits = acc_r.left_hits + new_hits;
      end else begin
        acc_nxt.right_hits = acc_r.right_hits + new_hits;
      end
      acc_nxt.weight_sum = acc_r.weight_sum + new_sum;
    end
  end

  always_ff @(posedge clk) begin
    bits_r  <= bits_nxt;
    digit_r <= digit_nxt;
    acc_r   <= acc_nxt;
  end

  assign scan = acc_r;

endmodule

// ===== design/lfs_divmul.sv =====
// Bit-serial restoring divide of the weight sum by the hit count, with the gain product built per quotient bit.
module lfs_divmul (
  input  logic           clk,
  input  logic           load,
  input  logic           step,
  input  lfs_pkg::scan_t scan,
  input  logic [11:0]    steer_gain,
  output lfs_pkg::quot_t res
);

  logic [2:0]  rem_r, rem_nxt;
  logic [3:0]  dvd_r, dvd_nxt;
  logic [lfs_pkg::QuotBits-1:0] quot_r, quot_nxt;
  logic [14:0] prod_r, prod_nxt;
  logic [5:0]  mag6;
  logic [3:0]  hits;
  logic [3:0]  trial;
  logic [3:0]  diff;
  logic        fits;

  always_comb begin
    mag6  = scan.weight_sum[5] ? 6'(-scan.weight_sum) : scan.weight_sum;
    hits  = {1'b0, scan.left_hits} + {1'b0, scan.right_hits};
    trial = {rem_r, dvd_r[3]};
    fits  = trial >= hits;
    diff  = trial - hits;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    prod_nxt = prod_r;
    if (load) begin
      rem_nxt  = {2'b00, mag6[4]};
      dvd_nxt  = mag6[3:0];
      quot_nxt = '0;
      prod_nxt = '0;
    end else if (step) begin
      rem_nxt  = fits ? diff[2:0] : trial[2:0];
      dvd_nxt  = {dvd_r[2:0], 1'b0};
      quot_nxt = {quot_r[lfs_pkg::QuotBits-2:0], fits};
      prod_nxt = {prod_r[13:0], 1'b0} + (fits ? {3'b000, steer_gain} : 15'd0);
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
    prod_r <= prod_nxt;
  end

  assign res.quot = quot_r;
  assign res.prod = prod_r;

endmodule

// ===== design/lfs_drive.sv =====
// Mode decision, steer selection and saturated drive values for one result word.
module lfs_drive (
  input  lfs_pkg::scan_t     scan,
  input  lfs_pkg::quot_t     dv,
  input  logic [9:0]         corner_steer,
  input  logic [14:0]        cruise_drive,
  input  logic signed [19:0] held_steer,
  input  logic               held_turn_side,
  input  logic signed [7:0]  held_position,
  output lfs_pkg::result_t   res
);

  function automatic logic signed [15:0] drive_value(input logic signed [24:0] s);
    logic signed [24:0] adj;
    logic signed [16:0] q;
    logic signed [15:0] d;
    adj = s[24] ? s + 25'sd255 : s;
    q   = adj[24:8];
    if (q > 17'sd32767) begin
      d = 16'sh7FFF;
    end else if (q < -17'sd32768) begin
      d = 16'sh8000;
    end else begin
      d = q[15:0];
    end
    return d;
  endfunction

  logic               hits_any;
  logic               turn_right;
  logic               turn_left;
  logic               sum_neg;
  logic signed [19:0] turn_mag;
  logic signed [7:0]  track_pos;
  logic signed [19:0] track_steer;
  logic signed [24:0] base_scaled;
  logic signed [24:0] steer_ext;

  always_comb begin
    hits_any   = (scan.left_hits != 3'd0) || (scan.right_hits != 3'd0);
    turn_right = (scan.right_hits >= lfs_pkg::TurnMinHits) &&
                 (scan.left_hits <= lfs_pkg::TurnMaxOther);
    turn_left  = (scan.left_hits >= lfs_pkg::TurnMinHits) &&
                 (scan.right_hits <= lfs_pkg::TurnMaxOther);
    sum_neg    = scan.weight_sum[5];
    turn_mag   = {2'b00, corner_steer, 8'h00};
    track_pos  = sum_neg ? -{4'b0000, dv.quot} : {4'b0000, dv.quot};
    track_steer = sum_neg ? -{5'b00000, dv.prod} : {5'b00000, dv.prod};

    priority if (turn_right) begin
      res.position   = held_position;
      res.steer      = turn_mag;
      res.track_mode = lfs_pkg::ModeTurn;
      res.turn_side  = 1'b1;
    end else if (turn_left) begin
      res.position   = held_position;
      res.steer      = -turn_mag;
      res.track_mode = lfs_pkg::ModeTurn;
      res.turn_side  = 1'b0;
    end else if (hits_any) begin
      res.position   = track_pos;
      res.steer      = track_steer;
      res.track_mode = lfs_pkg::ModeTrack;
      res.turn_side  = !sum_neg && (dv.quot != '0);
    end else begin
      res.position   = lfs_pkg::LostPosition;
      res.steer      = held_steer;
      res.track_mode = lfs_pkg::ModeLost;
      res.turn_side  = held_turn_side;
    end

    base_scaled     = {2'b00, cruise_drive, 8'h00};
    steer_ext       = {{5{res.steer[19]}}, res.steer};
    res.left_drive  = drive_value(base_scaled - steer_ext);
    res.right_drive = drive_value(base_scaled + steer_ext);
  end

endmodule

// ===== design/line_follow_steering.sv =====
// Top level of the line follow steering block: control sequencer, registers and output stage.
//
// Input stream: one 8-bit sensor snapshot per word on in_tdata, bit i is sensor i
// from the left, 0 means the sensor sees the line. Output stream: one result word
// per input word, carrying position, steer, turn side and both drive values in
// out_tdata and the tracking mode (lost, tracking, turn) in out_tuser.
// The block works on one word at a time: it scans the snapshot two sensors per cycle,
// loads the divider, runs the bit-serial divide that forms one quotient bit and one
// gain partial product per cycle, then selects the mode and writes the output register.
// A new word is accepted only once the last one is written to the output register.
// The output register holds a finished word while the receiver stalls; the next
// input word is accepted and processed meanwhile, and only the final cycle waits
// for the register to free up.
// Reset (rst_n low, synchronous) empties the pipeline, clears the held steer,
// turn side and position, and sets corner steer 0, steer gain 256 (1.0), cruise 0.
// Configuration writes (cfg_wr_en/cfg_index/cfg_wdata) only while idle: user duty, unchecked.
module line_follow_steering (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] sensor_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] position, [26:8] steer, [27] turn_side, [43:28] left_drive,
  // [59:44] right_drive, [63:60] zero
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser   // [1:0] track_mode
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  localparam logic [1:0] ScanLast = 2'(lfs_pkg::DigitCount - 1);
  localparam logic [1:0] DivLast  = 2'(lfs_pkg::QuotBits - 1);

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic [9:0]  corner_steer_r, corner_steer_nxt;
  logic [11:0] steer_gain_r, steer_gain_nxt;
  logic [14:0] cruise_drive_r, cruise_drive_nxt;

  logic signed [19:0] held_steer_r, held_steer_nxt;
  logic               held_turn_side_r, held_turn_side_nxt;
  logic signed [7:0]  held_position_r, held_position_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r, out_user_nxt;

  logic in_accept;
  logic out_free;
  logic fin_go;

  lfs_pkg::scan_t   scan;
  lfs_pkg::quot_t   dv;
  lfs_pkg::result_t res;

  assign in_tready = (state_r == StIdle);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign fin_go    = (state_r == StFin) && out_free;

  lfs_scan u_scan (
    .clk         (clk),
    .load        (in_accept),
    .shift       (state_r == StScan),
    .sensor_bits (in_tdata),
    .scan        (scan)
  );

  lfs_divmul u_divmul (
    .clk        (clk),
    .load       (state_r == StLoad),
    .step       (state_r == StDiv),
    .scan       (scan),
    .steer_gain (steer_gain_r),
    .res        (dv)
  );

  lfs_drive u_drive (
    .scan           (scan),
    .dv             (dv),
    .corner_steer   (corner_steer_r),
    .cruise_drive   (cruise_drive_r),
    .held_steer     (held_steer_r),
    .held_turn_side (held_turn_side_r),
    .held_position  (held_position_r),
    .res            (res)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 2'd1;
    unique case (state_r)
      StIdle: begin
        cnt_nxt = 2'd0;
        if (in_accept) begin
          state_nxt = StScan;
        end
      end
      StScan: begin
        if (cnt_r == ScanLast) begin
          state_nxt = StLoad;
        end
      end
      StLoad: begin
        cnt_nxt   = 2'd0;
        state_nxt = StDiv;
      end
      StDiv: begin
        if (cnt_r == DivLast) begin
          state_nxt = StFin;
        end
      end
      StFin: begin
        cnt_nxt = 2'd0;
        if (out_free) begin
          state_nxt = StIdle;
        end
      end
      default: begin
        cnt_nxt   = 2'd0;
        state_nxt = StIdle;
      end
    endcase
  end

  always_comb begin
    corner_steer_nxt = corner_steer_r;
    steer_gain_nxt   = steer_gain_r;
    cruise_drive_nxt = cruise_drive_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        lfs_pkg::CfgCornerSteer: corner_steer_nxt = cfg_wdata[9:0];
        lfs_pkg::CfgSteerGain:   steer_gain_nxt   = cfg_wdata[11:0];
        lfs_pkg::CfgCruiseDrive: cruise_drive_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    held_steer_nxt     = held_steer_r;
    held_turn_side_nxt = held_turn_side_r;
    held_position_nxt  = held_position_r;
    out_data_nxt       = out_data_r;
    out_user_nxt       = out_user_r;
    out_valid_nxt      = out_valid_r && !out_tready;
    if (fin_go) begin
      held_steer_nxt     = res.steer;
      held_turn_side_nxt = res.turn_side;
      held_position_nxt  = res.position;
      out_valid_nxt      = 1'b1;
      out_user_nxt       = res.track_mode;
      out_data_nxt       = {4'b0000, res.right_drive, res.left_drive, res.turn_side,
                            res.steer[18:0], res.position};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= StIdle;
      cnt_r            <= 2'd0;
      corner_steer_r   <= lfs_pkg::CornerSteerReset;
      steer_gain_r     <= lfs_pkg::SteerGainReset;
      cruise_drive_r   <= lfs_pkg::CruiseDriveReset;
      held_steer_r     <= '0;
      held_turn_side_r <= 1'b0;
      held_position_r  <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      cnt_r            <= cnt_nxt;
      corner_steer_r   <= corner_steer_nxt;
      steer_gain_r     <= steer_gain_nxt;
      cruise_drive_r   <= cruise_drive_nxt;
      held_steer_r     <= held_steer_nxt;
      held_turn_side_r <= held_turn_side_nxt;
      held_position_r  <= held_position_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== design/lfs_checker.sv =====
// Port-level checks for the line follow steering block, bound to the top level.
module lfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a word is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled output word changed");

  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == lfs_pkg::ModeLost || out_tuser == lfs_pkg::ModeTrack ||
                    out_tuser == lfs_pkg::ModeTurn))
    else $error("bad track mode");

  a_lost_position: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == lfs_pkg::ModeLost) |->
      (out_tdata[7:0] == lfs_pkg::LostPosition))
    else $error("lost word without lost position");

  a_track_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == lfs_pkg::ModeTrack) |->
      ($signed(out_tdata[7:0]) >= -8'sd8 && $signed(out_tdata[7:0]) <= 8'sd8))
    else $error("tracking position out of range");

endmodule

bind line_follow_steering lfs_checker u_lfs_checker (.*);

// ===== bench/line_follow_steering_tb.sv =====
// Self-checking testbench for line_follow_steering against a steering predictor.
module line_follow_steering_tb;

  localparam int DrainCycles = 16;
  localparam int CycleLimit = 800000;
  localparam int PhaseWords = 120;

  typedef struct {
    logic signed [7:0]  position;
    logic signed [18:0] steer;
    logic [1:0]         track_mode;
    logic               turn_side;
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
  } steering_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = lfs_pkg::CfgCornerSteer;
  logic [14:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'hFF;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  steering_word_t pending_words[$];
  int mismatches = 0;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int hold_request = 0;

  int line_weight[8] = '{-8, -6, -4, -1, 1, 4, 6, 8};
  int cfg_corner_steer;
  int cfg_steer_gain;
  int cfg_cruise_drive;
  int last_steer;
  int last_position;
  logic last_side;

  line_follow_steering i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  function automatic int drive_of(int scaled);
    int q;
    q = scaled / 256;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic steering_word_t steering_of(logic [7:0] bits);
    steering_word_t w;
    int left_hits;
    int right_hits;
    int weight_sum;
    int steer;
    int base_scaled;
    left_hits = 0;
    right_hits = 0;
    weight_sum = 0;
    for (int k = 0; k < lfs_pkg::SensorCount; k++) begin
      if (!bits[k]) begin
        if (k < lfs_pkg::SensorCount / 2) left_hits++;
        else right_hits++;
        weight_sum += line_weight[k];
      end
    end
    if (right_hits >= int'(lfs_pkg::TurnMinHits) &&
        left_hits <= int'(lfs_pkg::TurnMaxOther)) begin
      steer = cfg_corner_steer * 256;
      w.track_mode = lfs_pkg::ModeTurn;
      last_side = 1'b1;
      last_steer = steer;
    end else if (left_hits >= int'(lfs_pkg::TurnMinHits) &&
                 right_hits <= int'(lfs_pkg::TurnMaxOther)) begin
      steer = -(cfg_corner_steer * 256);
      w.track_mode = lfs_pkg::ModeTurn;
      last_side = 1'b0;
      last_steer = steer;
    end else if (left_hits + right_hits != 0) begin
      last_position = weight_sum / (left_hits + right_hits);
      steer = last_position * cfg_steer_gain;
      w.track_mode = lfs_pkg::ModeTrack;
      last_steer = steer;
      last_side = (last_position > 0);
    end else begin
      last_position = int'(lfs_pkg::LostPosition);
      steer = last_steer;
      w.track_mode = lfs_pkg::ModeLost;
    end
    base_scaled = cfg_cruise_drive * 256;
    w.position = last_position[7:0];
    w.steer = steer[18:0];
    w.turn_side = last_side;
    w.left_drive = 16'(drive_of(base_scaled - steer));
    w.right_drive = 16'(drive_of(base_scaled + steer));
    return w;
  endfunction

  task automatic send_snapshot(input logic [7:0] bits);
    int gap;
    gap = pick_gap(gap_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= bits;
    do @(posedge clk); while (!in_tready);
    pending_words.push_back(steering_of(bits));
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[14:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      lfs_pkg::CfgCornerSteer: cfg_corner_steer = value & 'h3FF;
      lfs_pkg::CfgSteerGain:   cfg_steer_gain = value & 'hFFF;
      lfs_pkg::CfgCruiseDrive: cfg_cruise_drive = value & 'h7FFF;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_all(input int corner, input int gain, input int cruise);
    write_reg(lfs_pkg::CfgCornerSteer, corner);
    write_reg(lfs_pkg::CfgSteerGain, gain);
    write_reg(lfs_pkg::CfgCruiseDrive, cruise);
  endtask

  function automatic logic [7:0] random_snapshot();
    logic [7:0] bits;
    int pick;
    int zeros_lo;
    int zeros_hi;
    pick = $urandom_range(99);
    if (pick < 10) return 8'hFF;
    if (pick < 20) return ~(8'h01 << $urandom_range(7));
    if (pick < 40) begin
      do begin
        bits = 8'($urandom);
        zeros_lo = 4 - $countones(bits[3:0]);
        zeros_hi = 4 - $countones(bits[7:4]);
      end while (!((zeros_hi >= 3 && zeros_lo <= 2) || (zeros_lo >= 3 && zeros_hi <= 2)));
      return bits;
    end
    return 8'($urandom);
  endfunction

  task automatic test_reset_values();
    send_snapshot(8'hFF);
    send_snapshot(8'h0F);
    send_snapshot(8'hFE);
    send_snapshot(8'h7F);
    settle();
  endtask

  task automatic test_directed_cases();
    logic [7:0] cases[$];
    cases = '{8'hFF, 8'h00, 8'hF0, 8'hFF, 8'h0F, 8'hFF, 8'hFE, 8'hFD, 8'hFB, 8'hF7,
              8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'hF6, 8'h6F, 8'h11, 8'hF1, 8'h8F, 8'h33,
              8'hCC, 8'h55, 8'hAA};
    write_all(1000, 256, 200);
    gap_pct = 0;
    stall_pct = 0;
    foreach (cases[k]) send_snapshot(cases[k]);
    settle();
  endtask

  task automatic test_register_sweep();
    int corner;
    int gain;
    int cruise;
    for (int p = 0; p < 11; p++) begin
      case (p)
        0: begin corner = 0; gain = 0; cruise = 0; end
        1: begin corner = 1000; gain = 4095; cruise = 32767; end
        2: begin corner = 0; gain = 4095; cruise = 0; end
        3: begin corner = 1000; gain = 0; cruise = 32767; end
        4: begin corner = 1; gain = 1; cruise = 1; end
        default: begin
          corner = $urandom_range(1000);
          gain = $urandom_range(4095);
          cruise = $urandom_range(32767);
        end
      endcase
      write_all(corner, gain, cruise);
      gap_pct = (p % 3 == 0) ? 0 : 30;
      stall_pct = (p % 3 == 0) ? 0 : 30;
      repeat (PhaseWords) send_snapshot(random_snapshot());
      settle();
    end
  endtask

  task automatic test_output_backpressure();
    write_all(500, 2048, 16000);
    gap_pct = 0;
    stall_pct = 0;
    hold_request = 400;
    repeat (30) send_snapshot(random_snapshot());
    stall_pct = 20;
    repeat (30) send_snapshot(random_snapshot());
    settle();
  endtask

  initial begin
    cfg_corner_steer = int'(lfs_pkg::CornerSteerReset);
    cfg_steer_gain = int'(lfs_pkg::SteerGainReset);
    cfg_cruise_drive = int'(lfs_pkg::CruiseDriveReset);
    last_steer = 0;
    last_position = 0;
    last_side = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_directed_cases();
    test_register_sweep();
    test_output_backpressure();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (rst_n && $urandom_range(99) < stall_pct) begin
        stall_left = pick_gap(100) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= rst_n;
      end
    end
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    steering_word_t w;
    if (out_tvalid === 1'b1 && out_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h/%h", $time, out_tuser,
                 out_tdata);
        mismatches++;
      end else begin
        w = pending_words.pop_front();
        compare_field("position", int'(w.position), int'($signed(out_tdata[7:0])));
        compare_field("steer", int'(w.steer), int'($signed(out_tdata[26:8])));
        compare_field("turn_side", int'(w.turn_side), int'(out_tdata[27]));
        compare_field("left_drive", int'(w.left_drive), int'($signed(out_tdata[43:28])));
        compare_field("right_drive", int'(w.right_drive), int'($signed(out_tdata[59:44])));
        compare_field("track_mode", int'(w.track_mode), int'(out_tuser));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
